>>> sv/rvwap_pkg.sv
// Package for the rolling VWAP crossover backtest.
// Holds field widths, ring depth, action codes and the front-to-back queue entry type.
`default_nettype none
package rvwap_pkg;
    localparam int unsigned RING_DEPTH = 1024;
    localparam int unsigned PRICE_W = 24;
    localparam int unsigned VOL_W   = 24;
    localparam int unsigned PV_W    = 58;
    localparam int unsigned VSUM_W  = 34;
    localparam int unsigned CASH_W  = 56;
    localparam int unsigned RET_W   = 48;
    localparam int unsigned CAP_W   = 40;
    localparam int unsigned FEE_W   = 16;
    localparam int unsigned WLEN_W  = 11;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_BUY  = 2'd1;
    localparam logic [1:0] ACT_SELL = 2'd2;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_FEE    = 2'd1;
    localparam logic [1:0] REG_CAP    = 2'd2;

    // classified tick handed from front to back
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               above;
        logic               below;
        logic               active;   // window full: signal counts
        logic               first;    // first tick of run: reload cash
        logic               last;
        logic               done_long;
    } t_tick;
endpackage
`default_nettype wire

>>> sv/rvwap_front.sv
// Front end: history ring, running sums and crossover classification.
// Depends on rvwap_pkg. Three internal steps per tick: read old entry, compare, update.
`default_nettype none
module rvwap_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [rvwap_pkg::WLEN_W-1:0]   i_window_len,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [rvwap_pkg::PRICE_W-1:0]  i_price,
    input  wire logic [rvwap_pkg::VOL_W-1:0]    i_volume,
    input  wire logic                           i_last,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output rvwap_pkg::t_tick                    o_tick
);
    localparam int unsigned DEPTH = rvwap_pkg::RING_DEPTH;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 2);
    localparam int unsigned PW = rvwap_pkg::PRICE_W;
    localparam int unsigned VW = rvwap_pkg::VOL_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001, S_CMP = 3'b010, S_OUT = 3'b100
    } t_fstate;

    t_fstate r_state, n_state;
    logic [PW+VW-1:0] r_mem [DEPTH];
    logic [PW+VW-1:0] r_rd;
    logic [PW-1:0] r_p, r_prev;
    logic [VW-1:0] r_v;
    logic r_last;
    logic [rvwap_pkg::PV_W-1:0] r_pv;
    logic [rvwap_pkg::VSUM_W-1:0] r_vs;
    logic [CW-1:0] r_seen;
    logic [AW-1:0] r_slot;
    rvwap_pkg::t_tick r_tick;
    logic [rvwap_pkg::PV_W-1:0] r_lhs, r_pvp, r_oldpv;

    logic [CW-1:0] w_eff;
    logic [AW-1:0] w_old;
    logic w_act;

    always_comb begin
        if (i_window_len == '0) w_eff = CW'(1);
        else if (i_window_len > rvwap_pkg::WLEN_W'(DEPTH)) w_eff = CW'(DEPTH);
        else w_eff = CW'(i_window_len);
    end
    assign w_act = (r_seen >= w_eff);
    assign w_old = r_slot - AW'(w_eff);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_tick  = r_tick;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_CMP;
            S_CMP:  n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_rd <= r_mem[w_old];
            r_p <= i_price; r_v <= i_volume; r_last <= i_last;
            r_lhs <= rvwap_pkg::PV_W'(i_price * r_vs);
            r_pvp <= rvwap_pkg::PV_W'(i_price * i_volume);
        end
        if (r_state == S_CMP) begin
            r_mem[r_slot] <= {r_v, r_p};
            r_oldpv <= rvwap_pkg::PV_W'(r_rd[PW-1:0] * r_rd[PW+VW-1:PW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv <= '0; r_vs <= '0; r_seen <= '0; r_slot <= '0;
            r_prev <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CMP) begin
                r_tick.price  <= r_p;
                r_tick.active <= w_act;
                r_tick.first  <= (r_seen == '0);
                r_tick.last   <= r_last;
                r_tick.done_long <= ((r_seen + CW'(1)) > w_eff);
                if (r_vs != '0) begin
                    r_tick.above <= r_lhs > r_pv;
                    r_tick.below <= r_lhs < r_pv;
                end else begin
                    r_tick.above <= r_p > r_prev;
                    r_tick.below <= r_p < r_prev;
                end
                r_slot <= r_slot + AW'(1);
                r_seen <= (r_seen + CW'(1) > w_eff + CW'(1)) ? w_eff + CW'(1)
                                                            : r_seen + CW'(1);
                r_prev <= r_p;
            end
            // sums update in S_OUT so old product is registered
            if (r_state == S_OUT && i_ready) begin
                if (r_tick.last) begin
                    r_pv <= '0; r_vs <= '0; r_seen <= '0; r_slot <= '0; r_prev <= '0;
                end else if (r_tick.active) begin
                    r_pv <= r_pv - r_oldpv + r_pvp;
                    r_vs <= r_vs - rvwap_pkg::VSUM_W'(r_rd[PW+VW-1:PW])
                          + rvwap_pkg::VSUM_W'(r_v);
                end else begin
                    r_pv <= r_pv + r_pvp;
                    r_vs <= r_vs + rvwap_pkg::VSUM_W'(r_v);
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/rvwap_queue.sv
// Two-entry queue between front and back ends.
// Depends on rvwap_pkg for the entry type.
`default_nettype none
module rvwap_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  rvwap_pkg::t_tick i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output rvwap_pkg::t_tick o_data
);
    rvwap_pkg::t_tick r_buf [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop  = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (w_push) r_buf[r_wp] <= i_data;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

>>> sv/rvwap_back.sv
// Back end: position, fee, saturating cash and the serial percent-return divider.
// Depends on rvwap_pkg.
`default_nettype none
module rvwap_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [rvwap_pkg::FEE_W-1:0]   i_fee,
    input  wire logic [rvwap_pkg::CAP_W-1:0]   i_cap,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  rvwap_pkg::t_tick                   i_tick,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_action,
    output logic                               o_holding,
    output logic signed [rvwap_pkg::CASH_W-1:0] o_cash,
    output logic signed [rvwap_pkg::RET_W-1:0] o_ret,
    output logic                               o_done
);
    localparam int unsigned CW = rvwap_pkg::CASH_W;
    localparam int unsigned RW = rvwap_pkg::RET_W;
    localparam int unsigned NW = 72;   // dividend: |diff|*25600 + s/2
    localparam int unsigned DW = 41;
    localparam logic [15:0] PCT = 16'd25600;
    localparam logic signed [CW+1:0] CASH_HI = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [CW+1:0] CASH_LO = {3'b111, {(CW-1){1'b0}}};
    localparam logic [NW-1:0] RET_LIM = NW'(1) << (RW - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_FEE = 5'b00010, S_TRADE = 5'b00100,
        S_DIV = 5'b01000, S_OUT = 5'b10000
    } t_bstate;

    t_bstate r_state;
    rvwap_pkg::t_tick r_t;
    logic [39:0] r_fee;
    logic signed [CW-1:0] r_cash;
    logic r_pos;
    logic [1:0] r_act;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [6:0] r_cnt;
    logic r_neg;
    logic [rvwap_pkg::CAP_W-1:0] r_s;

    logic signed [CW+1:0] w_base, w_buy, w_sell, w_mid, w_fin;
    logic w_b, w_s, w_liq;
    logic [rvwap_pkg::PRICE_W:0] w_pf, w_pm;
    logic [DW-1:0] w_trial;

    function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] x);
        if (x > CASH_HI) return CASH_HI[CW-1:0];
        if (x < CASH_LO) return CASH_LO[CW-1:0];
        return x[CW-1:0];
    endfunction

    assign w_pf = {1'b0, r_t.price} + (rvwap_pkg::PRICE_W+1)'(r_fee[39:16]);
    assign w_pm = {1'b0, r_t.price} - (rvwap_pkg::PRICE_W+1)'(r_fee[39:16]);
    assign w_base = r_t.first ? (CW+2)'(i_cap) : (CW+2)'(r_cash);
    assign w_b = r_t.active && r_t.above && !r_pos;
    assign w_s = r_t.active && r_t.below && r_pos;
    assign w_buy  = w_base - (CW+2)'(w_pf);
    assign w_sell = w_base + (CW+2)'(w_pm);
    assign w_mid  = w_b ? (CW+2)'(sat(w_buy)) : w_s ? (CW+2)'(sat(w_sell)) : w_base;
    assign w_liq  = r_t.last && (w_b || (r_pos && !w_s));
    assign w_fin  = w_liq ? (CW+2)'(sat(w_mid + (CW+2)'(w_pm))) : w_mid;
    assign w_trial = {r_rem[DW-2:0], r_num[NW-1]};

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_action = r_act;
    assign o_holding = r_pos;
    assign o_cash = r_cash;
    assign o_done = r_t.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_pos <= 1'b0; r_cash <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_t <= i_tick; r_state <= S_FEE;
                end
                S_FEE: begin
                    r_fee <= 40'(r_t.price * i_fee) + 40'd32768;
                    r_state <= S_TRADE;
                end
                S_TRADE: begin
                    logic signed [CW+1:0] d;
                    logic [CW+1:0] m;
                    logic [rvwap_pkg::CAP_W-1:0] s;
                    s = (i_cap == '0) ? rvwap_pkg::CAP_W'(1) : i_cap;
                    r_cash <= w_fin[CW-1:0];
                    r_act <= w_liq ? rvwap_pkg::ACT_SELL :
                             w_b ? rvwap_pkg::ACT_BUY :
                             w_s ? rvwap_pkg::ACT_SELL : rvwap_pkg::ACT_NONE;
                    r_pos <= r_t.last ? 1'b0 : (w_b ? 1'b1 : (w_s ? 1'b0 : r_pos));
                    d = w_fin - (CW+2)'(s);
                    r_neg <= d[CW+1];
                    m = d[CW+1] ? -d : d;
                    r_num <= NW'(m) * NW'(PCT) + NW'(s >> 1);
                    r_s <= s;
                    r_rem <= '0; r_cnt <= '0;
                    r_state <= (r_t.last && r_t.done_long) ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    // one quotient bit per cycle
                    if (w_trial >= DW'(r_s)) begin
                        r_rem <= w_trial - DW'(r_s);
                        r_num <= {r_num[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_num <= {r_num[NW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'(NW-1)) r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // saturate quotient to 48-bit signed
    always_comb begin
        logic [NW-1:0] q;
        q = r_num;
        if (!(r_t.last && r_t.done_long)) o_ret = '0;
        else if (r_neg) o_ret = (q >= RET_LIM) ? {1'b1, {(RW-1){1'b0}}} : -RW'(q);
        else o_ret = (q >= RET_LIM) ? {1'b0, {(RW-1){1'b1}}} : RW'(q);
    end
endmodule
`default_nettype wire

>>> sv/rolling_vwap_crossover_backtest.sv
// Rolling VWAP crossover backtest, top level.
// Path: front end read/compare/output steps, the queue, then the back end's accept/
//   fee/trade/output steps, which set the tick rate; a final tick of a run longer than
//   the window also passes the serial divider. Each end holds one tick at a time.
// Reset (i_rst_n low, synchronous) clears run state and loads register defaults;
//   the history ring is not cleared, the window gates reads to written entries.
// Depends on rvwap_pkg, rvwap_front, rvwap_queue, rvwap_back.
`default_nettype none
module rolling_vwap_crossover_backtest (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [39:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,   // tick_price[23:0], tick_volume[47:24]
    input  wire logic         s_axis_tlast,   // final_tick
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [111:0]      m_axis_tdata,   // action[1:0], holding[2], cash_now[58:3],
                                              // return_pct[106:59], zero fill
    output logic              m_axis_tlast    // run_done
);
    logic [rvwap_pkg::WLEN_W-1:0] r_wlen;
    logic [rvwap_pkg::FEE_W-1:0]  r_fee;
    logic [rvwap_pkg::CAP_W-1:0]  r_cap;

    // hold configuration; the user must write it only while idle, which is not enforced here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= 11'd20; r_fee <= '0; r_cap <= 40'd25600000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rvwap_pkg::REG_WINDOW: r_wlen <= i_cfg_data[10:0];
                rvwap_pkg::REG_FEE:    r_fee  <= i_cfg_data[15:0];
                rvwap_pkg::REG_CAP:    r_cap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready, q_valid, q_ready;
    rvwap_pkg::t_tick f_tick, q_tick;
    logic [1:0] w_act;
    logic w_hold;
    logic signed [55:0] w_cash;
    logic signed [47:0] w_ret;

    rvwap_front u_front (
        .i_clk, .i_rst_n, .i_window_len(r_wlen),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_price(s_axis_tdata[23:0]), .i_volume(s_axis_tdata[47:24]),
        .i_last(s_axis_tlast),
        .o_valid(f_valid), .i_ready(f_ready), .o_tick(f_tick));

    rvwap_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_data(f_tick),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_tick));

    rvwap_back u_back (
        .i_clk, .i_rst_n, .i_fee(r_fee), .i_cap(r_cap),
        .i_valid(q_valid), .o_ready(q_ready), .i_tick(q_tick),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_action(w_act), .o_holding(w_hold), .o_cash(w_cash), .o_ret(w_ret),
        .o_done(m_axis_tlast));

    assign m_axis_tdata = {5'd0, w_ret, w_cash, w_hold, w_act};
endmodule
`default_nettype wire

>>> sv/rvwap_checker.sv
// Port-level checker for the backtest top level, with its bind.
// Depends on the top level's ports only.
`default_nettype none
module rvwap_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [111:0] m_axis_tdata,
    input wire logic         m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");
    a_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad action code");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[2])
        else $error("position open after run end");
    a_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[106:59] == '0)
        else $error("return nonzero mid-run");
endmodule

bind rolling_vwap_crossover_backtest rvwap_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast);
`default_nettype wire
